// ===== hdl/w36unpk_pkg.sv =====
// ============================================================================
// w36unpk_pkg
// Shared types and constants for the 36-bit word text and byte unpacker.
// ============================================================================
`default_nettype none

package w36unpk_pkg;

    // Input item commands
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_EOF   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Character size codes held in the char_mode register
    localparam logic [1:0] MODE_7BIT    = 2'd0;
    localparam logic [1:0] MODE_8BIT    = 2'd1;
    localparam logic [1:0] MODE_IGNORED = 2'd2;

    // Configuration register indexes
    localparam logic REG_CHAR_MODE = 1'b0;
    localparam logic REG_KEEP_CR   = 1'b1;

    // Characters per word in each mode
    localparam int unsigned CHARS_7BIT = 5;
    localparam int unsigned CHARS_8BIT = 4;

    // Result slots: one carriage return slot ahead of each character slot
    localparam int unsigned NUM_CHARS = 5;
    localparam int unsigned NUM_SLOTS = 2 * NUM_CHARS;

    // Largest legal fifth tape byte
    localparam logic [7:0] FIFTH_MAX = 8'h0F;

    localparam logic [6:0] CHAR_CR = 7'h0D;
    localparam logic [6:0] CHAR_LF = 7'h0A;

endpackage : w36unpk_pkg

`default_nettype wire

// ===== hdl/word36_text_byte_unpacker.sv =====
// ============================================================================
// word36_text_byte_unpacker
// Unpacks 7-bit text or 8-bit bytes from 36-bit words held as five tape bytes.
// ============================================================================
//
// Input channel (in_valid / in_stall) carries one command per transfer:
// start file loads the byte count, a data word is unpacked, end of file
// flushes a held carriage return and reports the bytes left over.
// Output channel (out_valid / out_stall) carries one character per transfer,
// with last marking the final result of an input item; a dropped word or an
// end of file gives a single result instead.
// Configuration writes (cfg_valid / cfg_ready) set char_mode and keep_cr and
// are always taken; write them only while the block is idle.
// The first result of an item is registered and shows in the cycle after its
// transfer. A data word drains its results one per output transfer, up to
// six, as the output port carries one character. The next item is taken in
// the cycle the previous final result leaves. Reset clears the counter, the
// held carriage return, the configuration and the slot mask and tail flag of
// the result buffer, not its payload. While the receiver stalls, the result
// on the port holds and in_stall is raised once the current item still has
// results waiting.
`default_nettype none

module word36_text_byte_unpacker
    import w36unpk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [1:0]  cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [39:0] tape_word,
    input  wire logic [31:0] byte_total,
    // output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             byte_valid,
    output logic [7:0]       out_byte,
    output logic             last,
    output logic             bad_word,
    output logic [31:0]      bytes_left
);

    localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);

    // Configuration registers
    logic [1:0]  char_mode_reg;
    logic        keep_cr_reg;

    // Unpacking state
    logic        pending_cr_reg, pending_cr_next;
    logic [31:0] remaining_reg, remaining_next;

    // Result buffer: slot mask over CR/character pairs, or a single tail result
    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    logic [7:0]           chars_reg [NUM_CHARS];
    logic [7:0]           chars_next [NUM_CHARS];
    logic                 tail_reg, tail_next;
    logic                 tail_bv_reg, tail_bv_next;
    logic                 tail_bad_reg, tail_bad_next;
    logic [31:0]          tail_left_reg, tail_left_next;

    logic                 in_take;
    logic                 out_take;
    logic                 final_res;
    logic [SLOT_W-1:0]    slot_idx;
    logic [NUM_SLOTS-1:0] mask_rest;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_mode_reg <= MODE_7BIT;
            keep_cr_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CHAR_MODE: char_mode_reg <= cfg_data;
                REG_KEEP_CR:   keep_cr_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Pick the lowest pending slot and tell whether it is the final result
    always_comb
    begin
        slot_idx = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (mask_reg[s])
                slot_idx = SLOT_W'(s);
        end
    end

    assign mask_rest = mask_reg & (mask_reg - NUM_SLOTS'(1));
    assign out_valid = tail_reg || (|mask_reg);
    assign final_res = tail_reg || (mask_rest == '0);
    assign out_take  = out_valid && !out_stall;
    assign in_stall  = out_valid && !(out_take && final_res);
    assign in_take   = in_valid && !in_stall;

    // Drive the result port from the buffer
    always_comb
    begin
        if (tail_reg)
        begin
            byte_valid = tail_bv_reg;
            out_byte   = tail_bv_reg ? {1'b0, CHAR_CR} : 8'h00;
            last       = 1'b1;
            bad_word   = tail_bad_reg;
            bytes_left = tail_left_reg;
        end
        else
        begin
            byte_valid = out_valid;
            out_byte   = slot_idx[0] ? chars_reg[slot_idx[SLOT_W-1:1]] : {1'b0, CHAR_CR};
            last       = out_valid && final_res;
            bad_word   = 1'b0;
            bytes_left = '0;
        end
    end

    // Unpack one input item into the result buffer and next state
    always_comb
    begin
        logic [2:0]  per;
        logic [2:0]  n;
        logic [35:0] w36;
        logic [6:0]  c;
        logic        p;
        logic        take;

        per  = (char_mode_reg == MODE_7BIT) ? 3'(CHARS_7BIT) : 3'(CHARS_8BIT);
        n    = (remaining_reg < {29'd0, per}) ? remaining_reg[2:0] : per;
        w36  = {tape_word[39:8], tape_word[3:0]};
        p    = pending_cr_reg;
        c    = '0;
        take = 1'b0;

        pending_cr_next = pending_cr_reg;
        remaining_next  = remaining_reg;
        tail_next       = 1'b0;
        tail_bv_next    = 1'b0;
        tail_bad_next   = 1'b0;
        tail_left_next  = '0;
        mask_next       = '0;
        for (int i = 0; i < NUM_CHARS; i++)
            chars_next[i] = '0;

        case (cmd_t'(cmd))
            CMD_START:
            begin
                remaining_next  = byte_total;
                pending_cr_next = 1'b0;
            end
            CMD_EOF:
            begin
                tail_next       = 1'b1;
                tail_bv_next    = pending_cr_reg;
                tail_left_next  = remaining_reg;
                pending_cr_next = 1'b0;
            end
            CMD_DATA:
            begin
                if (char_mode_reg <= MODE_8BIT && remaining_reg != '0)
                begin
                    if (tape_word[7:0] > FIFTH_MAX)
                    begin
                        tail_next     = 1'b1;
                        tail_bad_next = 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < NUM_CHARS; i++)
                        begin
                            take = 3'(i) < n;
                            if (char_mode_reg == MODE_7BIT)
                            begin
                                c = w36[35 - 7*i -: 7];
                                chars_next[i] = {1'b0, c};
                                if (take)
                                begin
                                    mask_next[2*i]   = p && (c != CHAR_LF);
                                    mask_next[2*i+1] = (c != CHAR_CR) || keep_cr_reg;
                                    p = (c == CHAR_CR) && !keep_cr_reg;
                                end
                            end
                            else if (i < CHARS_8BIT)
                            begin
                                chars_next[i]    = tape_word[39 - 8*i -: 8];
                                mask_next[2*i+1] = take;
                            end
                        end
                        if (char_mode_reg == MODE_7BIT)
                            pending_cr_next = p;
                        remaining_next = remaining_reg - {29'd0, n};
                    end
                end
            end
            default: ;
        endcase
    end

    // Hold state and the result buffer; load on input transfer, drain on output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_cr_reg <= 1'b0;
            remaining_reg  <= '0;
            mask_reg       <= '0;
            tail_reg       <= 1'b0;
        end
        else if (in_take)
        begin
            pending_cr_reg <= pending_cr_next;
            remaining_reg  <= remaining_next;
            mask_reg       <= mask_next;
            tail_reg       <= tail_next;
        end
        else if (out_take)
        begin
            mask_reg <= mask_rest;
            tail_reg <= 1'b0;
        end
    end

    // Payload of the result buffer
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < NUM_CHARS; i++)
                chars_reg[i] <= chars_next[i];
            tail_bv_reg   <= tail_bv_next;
            tail_bad_reg  <= tail_bad_next;
            tail_left_reg <= tail_left_next;
        end
    end

`ifndef SYNTHESIS
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !(tail_reg && (|mask_reg)))
        else $error("tail result and character slots both pending");

    a_max_results: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(mask_reg) <= 6)
        else $error("more than six results buffered for one word");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && cmd == CMD_START) |=> (!pending_cr_reg && !out_valid))
        else $error("start file left a carriage return held or a result");

    a_eof_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && cmd == CMD_EOF) |=> (tail_reg && !pending_cr_reg && last))
        else $error("end of file did not give a single final result");
`endif

endmodule : word36_text_byte_unpacker

`default_nettype wire

// ===== tb/tb_word36_text_byte_unpacker.sv =====
// ----------------------------------------------------------------------------
// tb_word36_text_byte_unpacker
// Self-checking bench for the 36-bit word unpacker. Named tests drive start,
// data, end-of-file and none commands through one sender task; a monitor
// predicts the characters of each accepted command and checks every result
// transfer against them in order. Input idles and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_word36_text_byte_unpacker;
    import w36unpk_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE_CYC  = 8;
    localparam int RAND_ITEMS  = 390;

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  out_byte;
        logic        last;
        logic        bad_word;
        logic [31:0] bytes_left;
    } unpk_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [1:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    cmd_t        cmd;
    logic [39:0] tape_word;
    logic [31:0] byte_total;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        byte_valid;
    logic [7:0]  out_byte;
    logic        last;
    logic        bad_word;
    logic [31:0] bytes_left;

    // predictor copy of configuration and state
    logic [1:0]  cur_mode    = MODE_7BIT;
    logic        cur_keep_cr = 1'b0;
    logic        cr_held     = 1'b0;
    logic [31:0] chars_left  = 32'd0;

    unpk_result_t unpacked_chars[$];
    unpk_result_t got_result;
    unpk_result_t want_result;
    int           error_count = 0;
    int           idle_cycles = 0;
    int           burst_left  = 0;
    int           stall_count = 0;
    int           stall_style = 0;
    int           stall_cycle = 0;

    word36_text_byte_unpacker dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .tape_word  (tape_word),
        .byte_total (byte_total),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .byte_valid (byte_valid),
        .out_byte   (out_byte),
        .last       (last),
        .bad_word   (bad_word),
        .bytes_left (bytes_left)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic unpk_result_t make_result(logic vld, logic [7:0] ch, logic bad,
                                                 logic [31:0] left);
        unpk_result_t r;
        r.byte_valid = vld;
        r.out_byte   = ch;
        r.last       = 1'b0;
        r.bad_word   = bad;
        r.bytes_left = left;
        return r;
    endfunction

    // Work out the characters one accepted command yields and queue them
    function automatic void unpack_item(cmd_t c, logic [39:0] w, logic [31:0] t);
        unpk_result_t outs[$];
        logic [35:0]  w36;
        logic [6:0]   ch;
        int unsigned  per;
        int unsigned  n;
        case (c)
            CMD_START:
            begin
                chars_left = t;
                cr_held    = 1'b0;
            end
            CMD_EOF:
            begin
                outs.push_back(make_result(cr_held, cr_held ? {1'b0, CHAR_CR} : 8'h00,
                                           1'b0, chars_left));
                cr_held = 1'b0;
            end
            CMD_DATA:
            begin
                if ((cur_mode == MODE_7BIT || cur_mode == MODE_8BIT) && chars_left != 0)
                begin
                    if (w[7:0] > FIFTH_MAX)
                    begin
                        outs.push_back(make_result(1'b0, 8'h00, 1'b1, 32'd0));
                    end
                    else
                    begin
                        w36 = {w[39:8], w[3:0]};
                        per = (cur_mode == MODE_7BIT) ? CHARS_7BIT : CHARS_8BIT;
                        n   = (chars_left < per) ? chars_left : per;
                        for (int i = 0; i < n; i++)
                        begin
                            if (cur_mode == MODE_7BIT)
                            begin
                                ch = w36[35 - 7 * i -: 7];
                                if (cr_held && ch != CHAR_LF)
                                    outs.push_back(make_result(1'b1, {1'b0, CHAR_CR},
                                                               1'b0, 32'd0));
                                if (ch != CHAR_CR || cur_keep_cr)
                                    outs.push_back(make_result(1'b1, {1'b0, ch}, 1'b0, 32'd0));
                                cr_held = (ch == CHAR_CR) && !cur_keep_cr;
                            end
                            else
                            begin
                                outs.push_back(make_result(1'b1, w[39 - 8 * i -: 8],
                                                           1'b0, 32'd0));
                            end
                        end
                        chars_left = chars_left - n;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (outs.size() > 0)
            outs[outs.size() - 1].last = 1'b1;
        foreach (outs[k])
            unpacked_chars.push_back(outs[k]);
    endfunction

    // Track configuration, predict on input transfers, check output transfers
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_CHAR_MODE)
                    cur_mode = cfg_data;
                else
                    cur_keep_cr = cfg_data[0];
            end
            if (in_valid && !in_stall)
                unpack_item(cmd, tape_word, byte_total);
            if (out_valid && !out_stall)
            begin
                got_result = {byte_valid, out_byte, last, bad_word, bytes_left};
                if (unpacked_chars.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none", $time);
                    $display("%0t: actual valid=%b byte=%h last=%b bad=%b left=%h",
                             $time, byte_valid, out_byte, last, bad_word, bytes_left);
                    error_count++;
                end
                else
                begin
                    want_result = unpacked_chars.pop_front();
                    if (got_result !== want_result)
                    begin
                        $display("%0t: expected valid=%b byte=%h last=%b bad=%b left=%h",
                                 $time, want_result.byte_valid, want_result.out_byte,
                                 want_result.last, want_result.bad_word,
                                 want_result.bytes_left);
                        $display("%0t: actual   valid=%b byte=%h last=%b bad=%b left=%h",
                                 $time, byte_valid, out_byte, last, bad_word, bytes_left);
                        error_count++;
                    end
                end
            end
        end
    end

    // Drive receiver stalls from a style that is picked anew at random intervals
    always @(posedge clk)
    begin
        stall_cycle++;
        if (stall_count == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_count = $urandom_range(20, 80);
        end
        else
        begin
            stall_count--;
        end
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_cycle % 7) < 3);
        endcase
    end

    // Abort when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Hold one command until the transfer, idling between bursts
    task automatic send_item(input cmd_t c, input logic [39:0] w, input logic [31:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        cmd        <= c;
        tape_word  <= w;
        byte_total <= t;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid, wait for all predicted characters, then let the block go idle
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (unpacked_chars.size() != 0 || out_valid)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] val);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [39:0] pack_chars(logic [6:0] c0, logic [6:0] c1, logic [6:0] c2,
                                               logic [6:0] c3, logic [6:0] c4, logic spare);
        return {c0, c1, c2, c3, c4[6:3], 4'h0, c4[2:0], spare};
    endfunction

    function automatic logic [39:0] rand_word40();
        return {8'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [6:0] rand_text_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return CHAR_CR;
        if (r < 5)
            return CHAR_LF;
        return 7'($urandom_range(0, 127));
    endfunction

    task automatic test_seven_bit_text();
        write_reg(REG_CHAR_MODE, MODE_7BIT);
        write_reg(REG_KEEP_CR, 2'd0);
        send_item(CMD_START, rand_word40(), 32'd40);
        send_item(CMD_DATA, pack_chars(7'("H"), 7'("e"), 7'("l"), 7'("l"), 7'("o"), 1'b1),
                  $urandom);
        // CR before LF is stripped, CR before other text is kept
        send_item(CMD_DATA, pack_chars(CHAR_CR, CHAR_LF, 7'("a"), CHAR_CR, 7'("b"), 1'b0),
                  32'd0);
        // hold a CR across the word boundary, then resolve it with LF
        send_item(CMD_DATA, pack_chars(7'("x"), 7'("y"), 7'("z"), 7'("w"), CHAR_CR, 1'b0),
                  32'd0);
        send_item(CMD_DATA, pack_chars(CHAR_LF, 7'h00, 7'h7F, CHAR_CR, CHAR_CR, 1'b1), 32'd0);
        send_item(CMD_DATA, pack_chars(7'("q"), 7'h7F, 7'h00, 7'h7F, CHAR_CR, 1'b1),
                  32'hFFFFFFFF);
        // end of file flushes the held CR
        send_item(CMD_EOF, 40'hFF_FFFF_FFFF, 32'hFFFFFFFF);
        // fifth byte just above and at the top of its range
        send_item(CMD_DATA, 40'h12_3456_7810, 32'd0);
        send_item(CMD_DATA, 40'hFF_FFFF_FFFF, 32'd0);
        send_item(CMD_DATA, 40'hFF_FFFF_FF0F, 32'd0);
        // count runs out inside a word, then later words are ignored unchecked
        send_item(CMD_START, 40'd0, 32'd3);
        send_item(CMD_DATA, pack_chars(7'("A"), 7'("B"), 7'("C"), 7'("D"), 7'("E"), 1'b0),
                  32'd0);
        send_item(CMD_DATA, 40'hFF_FFFF_FFFF, 32'd0);
        send_item(CMD_EOF, 40'd0, 32'd0);
    endtask

    task automatic test_keep_cr();
        write_reg(REG_KEEP_CR, 2'd1);
        send_item(CMD_START, 40'd0, 32'hFFFFFFFF);
        send_item(CMD_DATA, pack_chars(CHAR_CR, CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF, 1'b0),
                  32'd0);
        send_item(CMD_EOF, 40'd0, 32'd0);
    endtask

    task automatic test_eight_bit();
        write_reg(REG_KEEP_CR, 2'd0);
        write_reg(REG_CHAR_MODE, MODE_7BIT);
        send_item(CMD_START, 40'd0, 32'd9);
        send_item(CMD_DATA, pack_chars(7'("a"), 7'("b"), 7'("c"), 7'("d"), CHAR_CR, 1'b0),
                  32'd0);
        // the held CR survives a switch to byte mode until end of file
        write_reg(REG_CHAR_MODE, MODE_8BIT);
        send_item(CMD_DATA, 40'hFF_FFFF_FF0F, 32'd0);
        send_item(CMD_EOF, 40'd0, 32'd0);
        send_item(CMD_START, 40'd0, 32'd2);
        send_item(CMD_DATA, 40'h0D_0A0D_0000, 32'd0);
    endtask

    task automatic test_ignored_size();
        write_reg(REG_CHAR_MODE, MODE_IGNORED);
        send_item(CMD_START, 40'd0, 32'd10);
        send_item(CMD_DATA, pack_chars(7'("z"), 7'("z"), 7'("z"), 7'("z"), 7'("z"), 1'b1),
                  32'd0);
        send_item(CMD_NONE, rand_word40(), $urandom);
        send_item(CMD_EOF, 40'd0, 32'd0);
    endtask

    // Random files: start, mostly well-formed words, noise, end of file
    task automatic test_random_files();
        int          items_sent;
        int          nwords;
        int          kind;
        int          r;
        logic [1:0]  mode;
        logic [31:0] total;
        logic [39:0] w;
        items_sent = 0;
        while (items_sent < RAND_ITEMS)
        begin
            r = $urandom_range(0, 9);
            mode = (r < 6) ? MODE_7BIT : (r < 9) ? MODE_8BIT : MODE_IGNORED;
            write_reg(REG_CHAR_MODE, mode);
            write_reg(REG_KEEP_CR, 2'($urandom_range(0, 1)));
            case ($urandom_range(0, 9))
                0:       total = 32'd0;
                1:       total = $urandom;
                default: total = $urandom_range(1, 48);
            endcase
            send_item(CMD_START, rand_word40(), total);
            items_sent++;
            nwords = $urandom_range(1, 12);
            for (int i = 0; i < nwords; i++)
            begin
                kind = $urandom_range(0, 19);
                if (kind == 0)
                begin
                    send_item(CMD_NONE, rand_word40(), $urandom);
                    items_sent++;
                end
                else if (kind == 1)
                begin
                    send_item(CMD_EOF, rand_word40(), $urandom);
                    items_sent++;
                end
                else if (kind == 2)
                begin
                    send_item(CMD_START, rand_word40(), $urandom_range(0, 20));
                    items_sent++;
                end
                else
                begin
                    if (mode == MODE_7BIT)
                        w = pack_chars(rand_text_char(), rand_text_char(), rand_text_char(),
                                       rand_text_char(), rand_text_char(),
                                       1'($urandom_range(0, 1)));
                    else
                        w = {32'($urandom), 4'h0, 4'($urandom)};
                    if ($urandom_range(0, 9) == 0)
                        w[7:4] = 4'($urandom_range(1, 15));
                    send_item(CMD_DATA, w, $urandom);
                    items_sent++;
                end
            end
            send_item(CMD_EOF, rand_word40(), $urandom);
            items_sent++;
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_CHAR_MODE;
        cfg_data   <= 2'd0;
        in_valid   <= 1'b0;
        cmd        <= CMD_START;
        tape_word  <= 40'd0;
        byte_total <= 32'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_seven_bit_text();
        test_keep_cr();
        test_eight_bit();
        test_ignored_size();
        test_random_files();

        settle_block();
        repeat (SETTLE_CYC) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/w36unpk_pkg.sv
hdl/word36_text_byte_unpacker.sv
tb/tb_word36_text_byte_unpacker.sv
